// ----- sv/tob_pkg.sv -----
// Package for the tick to OHLC bar builder: result codes, opcodes, sequencer states.
// No dependencies.
`default_nettype none
package tob_pkg;
	localparam int TimeW = 64;
	localparam int PriceW = 48;
	localparam int VolW = 64;
	localparam logic [62:0] PeriodReset = 63'd60000000000;

	typedef enum logic [1:0] {
		KIND_CLOSED = 2'd0,
		KIND_GAP    = 2'd1,
		KIND_SNAP   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_UPDATED = 3'd0,
		ST_NEW_BAR = 3'd1,
		ST_INVALID = 3'd2,
		ST_LATE    = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_BUCKET, S_DECIDE, S_GDIV, S_GSETUP, S_GSKIP,
		S_CLOSED, S_GAPADD, S_GAPOUT, S_SNAP, S_WAIT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage
`default_nettype wire

// ----- sv/tick_to_ohlc_bar_builder_top.sv -----
// Top level of the tick to OHLC bar builder: sequencer, bar state, result register.
// Depends on tob_pkg and tob_div.
//
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid/in_stall  | opcode, tick_time/price/volume/finite
//  out     | source    | out_valid/out_stall| item_kind .. last
//  cfg     | sink      | cfg_we             | cfg_data (bar period)
//
// A tick in the open or an earlier bucket runs from accept to the next accept through
// the bit-serial bucket division, then decide, snapshot, drain and idle.
// A later bucket adds the gap-count division, setup and step-back (the step-back walks
// only when gaps are dropped), the closed beat, and an add and an output step per gap beat.
// Invalid and clear beats skip the divider.
// Reset clears the open bar and loads the period register with 60 s.
// Stall on out holds the result register and the output steps of the sequencer;
// no new input beat is taken until the snapshot has left.
`default_nettype none
module tick_to_ohlc_bar_builder_top #(
	parameter int MAX_GAP_BARS = 62
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [63:0] tick_time,
	input  wire logic [47:0] tick_price,
	input  wire logic [47:0] tick_volume,
	input  wire logic        tick_finite,
	input  wire logic        cfg_we,
	input  wire logic [62:0] cfg_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       item_kind,
	output logic [2:0]       status,
	output logic [63:0]      bar_start,
	output logic [47:0]      bar_open,
	output logic [47:0]      bar_high,
	output logic [47:0]      bar_low,
	output logic [47:0]      bar_close,
	output logic [63:0]      bar_volume,
	output logic             bar_present,
	output logic [63:0]      gaps_dropped,
	output logic             last
);
	localparam logic [63:0] MaxGap = 64'(MAX_GAP_BARS);
	localparam logic [5:0]  SkipInit = 6'(MAX_GAP_BARS - 1);

	tob_pkg::state_t state_q, state_d;
	logic [62:0] period_q;
	logic [62:0] per_eff;

	// open bar
	logic        valid_q;
	logic [63:0] begin_q;
	logic [47:0] first_q, high_q, low_q, close_q;
	logic [63:0] vol_q;

	// captured input beat
	logic [63:0] t_q;
	logic [47:0] p_q;
	logic [47:0] v_q;
	logic [63:0] bucket_q;
	logic [63:0] drop_q;
	logic [63:0] gaps_q;
	logic [63:0] k_q;
	logic [63:0] gs_q;
	logic [5:0]  skip_q;
	logic [2:0]  st_q;

	// divider
	logic        div_start;
	logic [63:0] div_dvd;
	tob_pkg::div_ctl_t div_ctl;
	logic [63:0] div_quo, div_rem;

	// output register
	logic        ov_q;
	logic [1:0]  kind_q;
	logic [63:0] ostart_q;
	logic [47:0] oopen_q, ohigh_q, olow_q, oclose_q;
	logic [63:0] ovol_q;
	logic        opres_q, olast_q;

	logic out_free;
	logic load_beat;
	assign out_free  = !ov_q || !out_stall;
	assign per_eff   = (period_q == '0) ? 63'd1 : period_q;
	// a result beat enters the output register this cycle
	assign load_beat = out_free && (state_q == tob_pkg::S_CLOSED ||
		state_q == tob_pkg::S_GAPOUT || state_q == tob_pkg::S_SNAP);

	tob_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (per_eff),
		.ctl       (div_ctl),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// remainder to subtract, floor for negative times
	logic [63:0] r_floor;
	logic [64:0] bk_ext;
	logic [63:0] bucket_n;
	always_comb begin
		if (!t_q[63] || div_rem == '0) r_floor = div_rem;
		else r_floor = {1'b0, per_eff} - div_rem;
		bk_ext = {t_q[63], t_q} - {1'b0, r_floor};
		// saturate below the time range
		if (bk_ext[64] != bk_ext[63]) bucket_n = 64'h8000_0000_0000_0000;
		else bucket_n = bk_ext[63:0];
	end

	logic accept;
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != tob_pkg::S_IDLE);

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_dvd   = t_q[63] ? (~t_q + 64'd1) : t_q;
		unique case (state_q)
			tob_pkg::S_IDLE: begin
				if (accept) begin
					if (opcode == tob_pkg::OP_CLEAR || !tick_finite) state_d = tob_pkg::S_SNAP;
					else state_d = tob_pkg::S_DIV;
				end
			end
			tob_pkg::S_DIV: begin
				div_start = 1'b1;
				state_d   = tob_pkg::S_BUCKET;
			end
			tob_pkg::S_BUCKET: if (div_ctl.done) state_d = tob_pkg::S_DECIDE;
			tob_pkg::S_DECIDE: begin
				if (!valid_q || $signed(bucket_q) <= $signed(begin_q)) state_d = tob_pkg::S_SNAP;
				else begin
					div_start = 1'b1;
					div_dvd   = bucket_q - begin_q - 64'd1;
					state_d   = tob_pkg::S_GDIV;
				end
			end
			tob_pkg::S_GDIV: if (div_ctl.done) state_d = tob_pkg::S_GSETUP;
			tob_pkg::S_GSETUP: state_d = tob_pkg::S_GSKIP;
			tob_pkg::S_GSKIP: if (skip_q == '0) state_d = tob_pkg::S_CLOSED;
			tob_pkg::S_CLOSED: if (out_free) state_d = tob_pkg::S_GAPADD;
			tob_pkg::S_GAPADD: begin
				if (k_q > gaps_q) state_d = tob_pkg::S_SNAP;
				else state_d = tob_pkg::S_GAPOUT;
			end
			tob_pkg::S_GAPOUT: if (out_free) state_d = tob_pkg::S_GAPADD;
			tob_pkg::S_SNAP: if (out_free) state_d = tob_pkg::S_WAIT;
			tob_pkg::S_WAIT: if (out_free) state_d = tob_pkg::S_IDLE;
			default: state_d = tob_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tob_pkg::S_IDLE;
			period_q <= tob_pkg::PeriodReset;
			valid_q  <= 1'b0;
			begin_q  <= '0;
			first_q  <= '0;
			high_q   <= '0;
			low_q    <= '0;
			close_q  <= '0;
			vol_q    <= '0;
			ov_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) period_q <= cfg_data;
			// hold the beat while stalled, drop it once taken
			if (load_beat) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			unique case (state_q)
				tob_pkg::S_IDLE: begin
					if (accept && opcode == tob_pkg::OP_CLEAR) begin
						valid_q <= 1'b0;
						begin_q <= '0;
						first_q <= '0;
						high_q  <= '0;
						low_q   <= '0;
						close_q <= '0;
						vol_q   <= '0;
					end
				end
				tob_pkg::S_DECIDE: begin
					if (!valid_q) begin
						valid_q <= 1'b1;
						begin_q <= bucket_q;
						first_q <= p_q;
						high_q  <= p_q;
						low_q   <= p_q;
						close_q <= p_q;
						vol_q   <= {16'd0, v_q};
					end else if (bucket_q == begin_q) begin
						if ($signed(p_q) > $signed(high_q)) high_q <= p_q;
						if ($signed(p_q) < $signed(low_q)) low_q <= p_q;
						close_q <= p_q;
						vol_q   <= (vol_q > ~{16'd0, v_q}) ? '1 : vol_q + {16'd0, v_q};
					end
				end
				tob_pkg::S_GAPADD: begin
					if (k_q > gaps_q) begin
						// all gaps out: open the new bar
						valid_q <= 1'b1;
						begin_q <= bucket_q;
						first_q <= p_q;
						high_q  <= p_q;
						low_q   <= p_q;
						close_q <= p_q;
						vol_q   <= {16'd0, v_q};
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers: input capture, gap walk, result register
	always_ff @(posedge clk) begin
		unique case (state_q)
			tob_pkg::S_IDLE: begin
				if (accept) begin
					t_q    <= tick_time;
					p_q    <= tick_price;
					v_q    <= tick_volume;
					drop_q <= '0;
					if (opcode == tob_pkg::OP_CLEAR) st_q <= tob_pkg::ST_CLEARED;
					else if (!tick_finite) st_q <= tob_pkg::ST_INVALID;
				end
			end
			tob_pkg::S_BUCKET: if (div_ctl.done) bucket_q <= bucket_n;
			tob_pkg::S_DECIDE: begin
				if (!valid_q) st_q <= tob_pkg::ST_NEW_BAR;
				else if ($signed(bucket_q) < $signed(begin_q)) st_q <= tob_pkg::ST_LATE;
				else if (bucket_q == begin_q) st_q <= tob_pkg::ST_UPDATED;
				else st_q <= tob_pkg::ST_NEW_BAR;
			end
			tob_pkg::S_GSETUP: begin
				gaps_q <= div_quo;
				if (div_quo > MaxGap) begin
					drop_q <= div_quo - MaxGap;
					// newest gap starts at bucket - 1 - remainder; step back from there
					gs_q   <= bucket_q + ~div_rem;
					skip_q <= SkipInit;
				end else begin
					drop_q <= '0;
					gs_q   <= begin_q + {1'b0, per_eff};
					skip_q <= '0;
				end
			end
			tob_pkg::S_GSKIP: begin
				if (skip_q != '0) begin
					gs_q   <= gs_q - {1'b0, per_eff};
					skip_q <= skip_q - 6'd1;
				end
			end
			tob_pkg::S_CLOSED: begin
				if (out_free) begin
					kind_q   <= tob_pkg::KIND_CLOSED;
					ostart_q <= begin_q;
					oopen_q  <= first_q;
					ohigh_q  <= high_q;
					olow_q   <= low_q;
					oclose_q <= close_q;
					ovol_q   <= vol_q;
					opres_q  <= 1'b0;
					olast_q  <= 1'b0;
					k_q      <= drop_q + 64'd1;
				end
			end
			tob_pkg::S_GAPADD: ;
			tob_pkg::S_GAPOUT: begin
				if (out_free) begin
					kind_q   <= tob_pkg::KIND_GAP;
					oopen_q  <= '0;
					ohigh_q  <= '0;
					olow_q   <= '0;
					oclose_q <= '0;
					ovol_q   <= '0;
					opres_q  <= 1'b0;
					olast_q  <= 1'b0;
					ostart_q <= gs_q;
					k_q      <= k_q + 64'd1;
					gs_q     <= gs_q + {1'b0, per_eff};
				end
			end
			tob_pkg::S_SNAP: begin
				if (out_free) begin
					kind_q   <= tob_pkg::KIND_SNAP;
					ostart_q <= valid_q ? begin_q : '0;
					oopen_q  <= valid_q ? first_q : '0;
					ohigh_q  <= valid_q ? high_q : '0;
					olow_q   <= valid_q ? low_q : '0;
					oclose_q <= valid_q ? close_q : '0;
					ovol_q   <= valid_q ? vol_q : '0;
					opres_q  <= valid_q;
					olast_q  <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = ov_q;
	assign item_kind    = kind_q;
	assign status       = st_q;
	assign bar_start    = ostart_q;
	assign bar_open     = oopen_q;
	assign bar_high     = ohigh_q;
	assign bar_low      = olow_q;
	assign bar_close    = oclose_q;
	assign bar_volume   = ovol_q;
	assign bar_present  = opres_q;
	assign gaps_dropped = drop_q;
	assign last         = olast_q;
endmodule
`default_nettype wire

// ----- sv/tob_div.sv -----
// Bit-serial restoring divider: 64-bit unsigned dividend by 63-bit divisor, one bit a cycle.
// Depends on tob_pkg for the control struct.
`default_nettype none
module tob_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [63:0]          dividend,
	input  wire logic [62:0]          divisor,
	output tob_pkg::div_ctl_t         ctl,
	output logic      [63:0]          quotient,
	output logic      [63:0]          remainder
);
	logic [63:0] quo_q;
	logic [63:0] rem_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;
	logic [64:0] shifted;

	assign shifted = {rem_q, quo_q[63]};
	assign trial   = shifted - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
				done_q <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			// shift one dividend bit in, subtract when it fits
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

// ----- sv/tob_checker.sv -----
// Port-level checker for the bar builder, bound to the top level.
// Depends on tob_pkg for kind codes.
`default_nettype none
module tob_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] item_kind,
	input wire logic       last,
	input wire logic       bar_present
);
	a_last_snap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> item_kind == tob_pkg::KIND_SNAP)
		else $error("last beat is not a snapshot");
	a_snap_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == tob_pkg::KIND_SNAP |-> last)
		else $error("snapshot without last");
	a_pres: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bar_present |-> item_kind == tob_pkg::KIND_SNAP)
		else $error("present on non-snapshot");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(item_kind))
		else $error("stalled beat changed");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("input beat withdrawn while stalled");
endmodule

bind tick_to_ohlc_bar_builder_top tob_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .item_kind(item_kind),
	.last(last), .bar_present(bar_present)
);
`default_nettype wire
